@@ src/ptc_pkg.sv @@
`default_nettype none

package ptc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CAL_LO  = 3'd0,
    CFG_CAL_MID = 3'd1,
    CFG_CAL_HI  = 3'd2,
    CFG_MIN_PA  = 3'd3,
    CFG_MAX_PA  = 3'd4,
    CFG_LOADED  = 3'd5
  } cfg_idx_t;

  localparam int CalBytes = 21;

  // Reset limits in pascal
  localparam logic [16:0] MIN_PA_RST = 17'd30000;
  localparam logic [16:0] MAX_PA_RST = 17'd125000;

  // Temperature clamp limits in Q48 (-40 C and 85 C)
  localparam logic signed [61:0] T_MIN_Q48 = -62'sd11258999068426240;
  localparam logic signed [61:0] T_MAX_Q48 = 62'sd23925373020405760;

  // Decoded calibration coefficients; offsets already removed from P1, P2
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [16:0] t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1m;
    logic signed [16:0] p2m;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic signed [16:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coef_t;

  // Result of one item
  typedef struct packed {
    logic signed [23:0] temp_q16;
    logic signed [37:0] pres_q6;
    logic               pres_ok;
    logic               not_ready;
  } ptc_res_t;

endpackage

`default_nettype wire

@@ src/ptc_calc.sv @@
`default_nettype none

module ptc_calc (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  in_vld,
  input  wire  [23:0]          raw_p,
  input  wire  [23:0]          raw_t,
  input  wire                  not_rdy,
  input  wire  ptc_pkg::coef_t coef,
  input  wire  [16:0]          min_pa,
  input  wire  [16:0]          max_pa,
  output logic                 out_vld,
  output ptc_pkg::ptc_res_t    res
);
  import ptc_pkg::*;

  localparam int NStg = 12;

  // Valid, not-ready and raw pressure travel beside the data
  logic             vld_r [1:NStg];
  logic             nr_r  [1:NStg];
  logic [23:0]      p_r   [1:9];
  logic             vld_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NStg; i++) vld_r[i] <= 1'b0;
      vld_o_r <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_vld;
      for (int i = 2; i <= NStg; i++) vld_r[i] <= vld_r[i-1];
      vld_o_r <= vld_r[NStg];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr_r[1] <= not_rdy;
      for (int i = 2; i <= NStg; i++) nr_r[i] <= nr_r[i-1];
      p_r[1] <= raw_p;
      for (int i = 2; i <= 9; i++) p_r[i] <= p_r[i-1];
    end
  end

  logic signed [24:0] ps4, ps6, ps9;
  assign ps4 = $signed({1'b0, p_r[4]});
  assign ps6 = $signed({1'b0, p_r[6]});
  assign ps9 = $signed({1'b0, p_r[9]});

  // Stage 1: temperature offset d
  logic signed [24:0] d_r, d_nxt;
  assign d_nxt = $signed({1'b0, raw_t}) - $signed({1'b0, coef.t1, 8'h00});

  // Stage 2: d*T2 and d*d
  logic signed [41:0] dt2_r, dt2_nxt;
  logic signed [49:0] dd_r, dd_nxt;
  assign dt2_nxt = d_r * coef.t2;
  assign dd_nxt  = d_r * d_r;

  // Stage 3: temperature in Q48
  logic signed [57:0] ddt3;
  logic signed [61:0] nt_r, nt_nxt;
  assign ddt3   = dd_r * coef.t3;
  assign nt_nxt = (62'(dt2_r) <<< 18) + 62'(ddt3);

  // Stage 4: clamp, floor to Q16
  logic signed [61:0] ntc;
  logic signed [23:0] t4_r, t4_nxt;
  always_comb begin
    ntc = nt_r;
    if (nt_r < T_MIN_Q48) ntc = T_MIN_Q48;
    if (nt_r > T_MAX_Q48) ntc = T_MAX_Q48;
  end
  assign t4_nxt = ntc[55:32];

  // Stage 5: t^2, P6*t, P*P11
  logic signed [23:0] t5_r;
  logic signed [47:0] tt5_r, tt5_nxt;
  logic signed [40:0] p6t5_r, p6t5_nxt;
  logic signed [32:0] pp11_r, pp11_nxt;
  assign tt5_nxt  = t4_r * t4_r;
  assign p6t5_nxt = coef.p6 * t4_r;
  assign pp11_nxt = ps4 * coef.p11;

  // Stage 6: halves of t^3, t^2 terms, inner Horner value x
  logic signed [23:0] t6_r;
  logic signed [48:0] tl_r, tl_nxt;
  logic signed [47:0] th_r, th_nxt;
  logic signed [55:0] p7tt_r, p7tt_nxt, p3tt_r, p3tt_nxt;
  logic signed [40:0] q2_r, q2_nxt, p6t6_r;
  logic signed [31:0] p10t;
  logic signed [55:0] x_r, x_nxt;
  assign tl_nxt   = t5_r * $signed({1'b0, tt5_r[23:0]});
  assign th_nxt   = t5_r * $signed({1'b0, tt5_r[46:24]});
  assign p7tt_nxt = coef.p7 * tt5_r;
  assign p3tt_nxt = coef.p3 * tt5_r;
  assign q2_nxt   = coef.p2m * t5_r;
  assign p10t     = coef.p10 * t5_r;
  assign x_nxt    = (56'(coef.p9) <<< 37) + (56'(p10t) <<< 21) + (56'(pp11_r) <<< 20);

  // Stage 7: t^3, P*x partials, constant parts of C1 and C0
  logic signed [71:0]  t3_r, t3_nxt;
  logic signed [53:0]  pxl_r, pxl_nxt;
  logic signed [52:0]  pxh_r, pxh_nxt;
  logic signed [83:0]  c1a7_r, c1a7_nxt;
  logic signed [111:0] c0a7_r, c0a7_nxt;
  assign t3_nxt   = (72'(th_r) <<< 24) + 72'(tl_r);
  assign pxl_nxt  = ps6 * $signed({1'b0, x_r[27:0]});
  assign pxh_nxt  = ps6 * $signed(x_r[55:28]);
  assign c1a7_nxt = (84'(coef.p1m) <<< 65) + (84'(q2_r) <<< 40) + (84'(p3tt_r) <<< 21);
  assign c0a7_nxt = (112'($signed({1'b0, coef.p5})) <<< 88) + (112'(p6t6_r) <<< 63)
                  + (112'(p7tt_r) <<< 45);

  // Stage 8: P4*t^3, P8*t^3, y = P*x
  logic signed [79:0]  p4t3_r, p4t3_nxt, p8t3_r, p8t3_nxt;
  logic signed [83:0]  y_r, y_nxt, c1a8_r;
  logic signed [111:0] c0a8_r;
  assign p4t3_nxt = coef.p4 * t3_r;
  assign p8t3_nxt = coef.p8 * t3_r;
  assign y_nxt    = (84'(pxh_r) <<< 28) + 84'(pxl_r);

  // Stage 9: z = C1 + y, full C0
  logic signed [83:0]  z_r, z_nxt;
  logic signed [111:0] c09_r, c09_nxt;
  assign z_nxt   = c1a8_r + 84'(p4t3_r) + y_r;
  assign c09_nxt = c0a8_r + (112'(p8t3_r) <<< 22);

  // Stage 10: P*z in three partial products
  logic signed [53:0]  m0_r, m0_nxt, m1_r, m1_nxt;
  logic signed [52:0]  m2_r, m2_nxt, m2b_r;
  logic signed [111:0] c010_r;
  assign m0_nxt = ps9 * $signed({1'b0, z_r[27:0]});
  assign m1_nxt = ps9 * $signed({1'b0, z_r[55:28]});
  assign m2_nxt = ps9 * $signed(z_r[83:56]);

  // Stage 11 and 12: final sum in Q85
  logic signed [111:0] sa_r, sa_nxt, s_r, s_nxt;
  assign sa_nxt = c010_r + (112'(m1_r) <<< 28) + 112'(m0_r);
  assign s_nxt  = sa_r + (112'(m2b_r) <<< 56);

  // Temperature carried to the output
  logic signed [23:0] tq_r [7:12];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      dt2_r  <= dt2_nxt;
      dd_r   <= dd_nxt;
      nt_r   <= nt_nxt;
      t4_r   <= t4_nxt;
      t5_r   <= t4_r;
      tt5_r  <= tt5_nxt;
      p6t5_r <= p6t5_nxt;
      pp11_r <= pp11_nxt;
      t6_r   <= t5_r;
      tl_r   <= tl_nxt;
      th_r   <= th_nxt;
      p7tt_r <= p7tt_nxt;
      p3tt_r <= p3tt_nxt;
      q2_r   <= q2_nxt;
      p6t6_r <= p6t5_r;
      x_r    <= x_nxt;
      t3_r   <= t3_nxt;
      pxl_r  <= pxl_nxt;
      pxh_r  <= pxh_nxt;
      c1a7_r <= c1a7_nxt;
      c0a7_r <= c0a7_nxt;
      p4t3_r <= p4t3_nxt;
      p8t3_r <= p8t3_nxt;
      y_r    <= y_nxt;
      c1a8_r <= c1a7_r;
      c0a8_r <= c0a7_r;
      z_r    <= z_nxt;
      c09_r  <= c09_nxt;
      m0_r   <= m0_nxt;
      m1_r   <= m1_nxt;
      m2_r   <= m2_nxt;
      c010_r <= c09_r;
      sa_r   <= sa_nxt;
      m2b_r  <= m2_r;
      s_r    <= s_nxt;
      tq_r[7] <= t6_r;
      for (int i = 8; i <= 12; i++) tq_r[i] <= tq_r[i-1];
    end
  end

  // Output stage: floor to Q6, range check, not-ready masking.
  // The 33-bit Q6 value always fits the 38-bit field, so no saturation occurs.
  logic signed [32:0] q6;
  logic               rng;
  ptc_res_t           res_r, res_nxt;
  assign q6  = s_r[111:79];
  assign rng = (q6 >= $signed({1'b0, min_pa, 6'b0})) && (q6 <= $signed({1'b0, max_pa, 6'b0}));

  always_comb begin
    res_nxt.temp_q16  = tq_r[12];
    res_nxt.pres_q6   = 38'(q6);
    res_nxt.pres_ok   = rng;
    res_nxt.not_ready = 1'b0;
    if (nr_r[NStg]) begin
      res_nxt = '0;
      res_nxt.not_ready = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign out_vld = vld_o_r;
  assign res     = res_r;

endmodule

`default_nettype wire

@@ src/pressure_temp_compensation.sv @@
`default_nettype none

// Barometric pressure and temperature compensation. Each input item carries a
// raw 24-bit pressure and a raw 24-bit temperature; each result item carries the
// temperature in 1/65536 C (clamped to -40..85 C), the pressure in 1/64 Pa, an
// in-range flag against the programmed pascal limits and a not-ready flag that is
// set, with all other fields zero, while no calibration is marked loaded. The 21
// calibration bytes and the limits are to be written through the cfg port only
// while the block is idle; the block itself does not enforce this. One item is
// accepted every cycle unless a waiting result holds the input; a chain of
// registered multipliers evaluates the temperature and the cubic pressure
// polynomial exactly. A waiting result stalls the whole pipeline in place.
module pressure_temp_compensation (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: raw_pressure[23:0], raw_temperature[47:24]
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,
  // out_tdata: temperature_q16[23:0], pressure_q6[61:24], zero pad[63:62]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,
  // out_tuser: pres_ok[0], not_ready[1]
  output logic [1:0]  out_tuser,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_data
);
  import ptc_pkg::*;

  // Configuration registers
  logic [63:0] cal_lo_r, cal_mid_r;
  logic [39:0] cal_hi_r;
  logic [16:0] min_pa_r, max_pa_r;
  logic        loaded_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_lo_r  <= '0;
      cal_mid_r <= '0;
      cal_hi_r  <= '0;
      min_pa_r  <= MIN_PA_RST;
      max_pa_r  <= MAX_PA_RST;
      loaded_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAL_LO:  cal_lo_r  <= cfg_data;
        CFG_CAL_MID: cal_mid_r <= cfg_data;
        CFG_CAL_HI:  cal_hi_r  <= cfg_data[39:0];
        CFG_MIN_PA:  min_pa_r  <= cfg_data[16:0];
        CFG_MAX_PA:  max_pa_r  <= cfg_data[16:0];
        CFG_LOADED:  loaded_r  <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Coefficient decode, byte pairs little endian
  logic [8*CalBytes-1:0] cal;
  coef_t                 coef;
  assign cal = {cal_hi_r, cal_mid_r, cal_lo_r};

  always_comb begin
    coef.t1  = cal[15:0];
    coef.t2  = $signed({1'b0, cal[31:16]});
    coef.t3  = $signed(cal[39:32]);
    coef.p1m = 17'($signed(cal[55:40])) - 17'sd16384;
    coef.p2m = 17'($signed(cal[71:56])) - 17'sd16384;
    coef.p3  = $signed(cal[79:72]);
    coef.p4  = $signed(cal[87:80]);
    coef.p5  = cal[103:88];
    coef.p6  = $signed({1'b0, cal[119:104]});
    coef.p7  = $signed(cal[127:120]);
    coef.p8  = $signed(cal[135:128]);
    coef.p9  = $signed(cal[151:136]);
    coef.p10 = $signed(cal[159:152]);
    coef.p11 = $signed(cal[167:160]);
  end

  // Pipeline advances unless a result is held
  logic     en;
  ptc_res_t res;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  ptc_calc u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .raw_p   (in_tdata[23:0]),
    .raw_t   (in_tdata[47:24]),
    .not_rdy (!loaded_r),
    .coef    (coef),
    .min_pa  (min_pa_r),
    .max_pa  (max_pa_r),
    .out_vld (out_tvalid),
    .res     (res)
  );

  assign out_tdata = {2'b00, res.pres_q6, res.temp_q16};
  assign out_tuser = {res.not_ready, res.pres_ok};

endmodule

`default_nettype wire

@@ tb/pressure_temp_compensation_tb.sv @@
`default_nettype none

module pressure_temp_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptc_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 40;
  localparam int PhaseItems = 140;
  // cfg_index codes past the last register; writes to them are dropped
  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;

  // Plausible calibration: T1 0x6B8C, T2 0x4A2E, T3 -7, P1..P11 in sensor-like ranges
  localparam logic [63:0] TYP_CAL_LO  = 64'h9B0A3FF94A2E6B8C;
  localparam logic [63:0] TYP_CAL_MID = 64'h037B6E63D201230C;
  localparam logic [39:0] TYP_CAL_HI  = 40'hEC071A4BFA;

  typedef struct packed {
    logic [23:0] raw_p;
    logic [23:0] raw_t;
    logic        load_cal;   // load the plausible calibration before this item
    logic        typed;      // compare with exp_res instead of the predictor
    ptc_res_t    exp_res;
  } dir_row_t;

  localparam ptc_res_t NOT_READY_RES = '{temp_q16: '0, pres_q6: '0, pres_ok: 1'b0,
                                          not_ready: 1'b1};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // predictor's copy of the registers
  logic [7:0]  cal_byte [CalBytes];
  logic [16:0] lim_min_pa;
  logic [16:0] lim_max_pa;
  logic        cal_loaded;

  ptc_res_t    pending_res_q [$];
  int          err_cnt;
  int          cycle_cnt;
  int          hold_cycles;
  logic        rx_always_ready;

  pressure_temp_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // calibration byte decoders
  function automatic longint cal_u16(input int i);
    return longint'({cal_byte[i + 1], cal_byte[i]});
  endfunction

  function automatic longint cal_s16(input int i);
    return longint'($signed({cal_byte[i + 1], cal_byte[i]}));
  endfunction

  function automatic longint cal_s8(input int i);
    return longint'($signed(cal_byte[i]));
  endfunction

  // register write as the block sees it
  function automatic void cal_reg_write(input logic [2:0] idx, input logic [63:0] val);
    int base;
    int n;
    base = int'(idx) * 8;
    n = (idx == CFG_CAL_HI) ? 5 : 8;
    case (idx)
      CFG_MIN_PA: lim_min_pa = val[16:0];
      CFG_MAX_PA: lim_max_pa = val[16:0];
      CFG_LOADED: cal_loaded = val[0];
      CFG_CAL_LO, CFG_CAL_MID, CFG_CAL_HI: begin
        for (int i = 0; i < n; i++) cal_byte[base + i] = val[8 * i +: 8];
      end
      default: ;
    endcase
  endfunction

  // exact compensation: Q48 temperature, pressure sum scaled by 2^85
  function automatic ptc_res_t compensate(input logic [23:0] raw_p, input logic [23:0] raw_t);
    logic signed [127:0] pr;
    logic signed [127:0] d;
    logic signed [127:0] nt;
    logic signed [127:0] t;
    logic signed [127:0] tt;
    logic signed [127:0] acc;
    logic signed [127:0] q;
    logic signed [127:0] lo_lim;
    logic signed [127:0] hi_lim;
    logic                sat;
    ptc_res_t            r;
    r = NOT_READY_RES;
    if (!cal_loaded) return r;
    pr = $signed({104'd0, raw_p});
    d = $signed({104'd0, raw_t}) - cal_u16(0) * 256;
    nt = d * cal_u16(2) * 262144 + d * d * cal_s8(4);
    if (nt < T_MIN_Q48) nt = T_MIN_Q48;
    if (nt > T_MAX_Q48) nt = T_MAX_Q48;
    t = nt >>> 32;
    tt = t * t;
    acc = ((cal_u16(11) * 8) <<< 85)
        + ((cal_u16(13) * t) <<< 63)
        + ((cal_s8(15) * tt) <<< 45)
        + ((cal_s8(16) * tt * t) <<< 22)
        + ((pr * (cal_s16(5) - 16384)) <<< 65)
        + ((pr * (cal_s16(7) - 16384) * t) <<< 40)
        + ((pr * cal_s8(9) * tt) <<< 21)
        + (pr * cal_s8(10) * t * tt)
        + ((pr * pr * cal_s16(17)) <<< 37)
        + ((pr * pr * cal_s8(19) * t) <<< 21)
        + ((pr * pr * pr * cal_s8(20)) <<< 20);
    q = acc >>> 79;
    sat = 1'b0;
    if (q > (128'sd1 <<< 37) - 1) begin
      q = (128'sd1 <<< 37) - 1;
      sat = 1'b1;
    end
    if (q < -(128'sd1 <<< 37)) begin
      q = -(128'sd1 <<< 37);
      sat = 1'b1;
    end
    lo_lim = $signed({111'd0, lim_min_pa}) * 64;
    hi_lim = $signed({111'd0, lim_max_pa}) * 64;
    r.temp_q16 = t[23:0];
    r.pres_q6 = q[37:0];
    r.pres_ok = !sat && q >= lo_lim && q <= hi_lim;
    r.not_ready = 1'b0;
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    ptc_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res_q.size() == 0) begin
        report("unexpected item", out_tdata, 64'd0);
      end else begin
        want = pending_res_q.pop_front();
        if (out_tdata[23:0] !== want.temp_q16) report("temperature_q16",
                                                      64'(out_tdata[23:0]),
                                                      64'(want.temp_q16));
        if (out_tdata[61:24] !== want.pres_q6) report("pressure_q6", 64'(out_tdata[61:24]),
                                                      64'(want.pres_q6));
        if (out_tdata[63:62] !== 2'b00) report("pad", 64'(out_tdata[63:62]), 64'd0);
        if (out_tuser[0] !== want.pres_ok) report("pres_ok", 64'(out_tuser[0]),
                                                  64'(want.pres_ok));
        if (out_tuser[1] !== want.not_ready) report("not_ready", 64'(out_tuser[1]),
                                                    64'(want.not_ready));
      end
    end
  end

  // receiver: random stalls, forced holds, or always ready
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_always_ready) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      out_tready <= 1'b0;
      hold_cycles <= $urandom_range(10, 50);
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // long receiver hold, armed at a rising edge so the receiver's updates cannot clash
  task automatic hold_rx(input int n);
    @(posedge clk);
    hold_cycles = n;
    @(negedge clk);
  endtask

  task automatic send_item(input logic [23:0] raw_p, input logic [23:0] raw_t,
                           input logic typed, input ptc_res_t typed_res, input int gap);
    in_tvalid = 1'b1;
    in_tdata = {raw_t, raw_p};
    do @(posedge clk); while (!in_tready);
    pending_res_q.push_back(typed ? typed_res : compensate(raw_p, raw_t));
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata = 48'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_res_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    cal_reg_write(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int rand_gap();
    int g;
    g = $urandom_range(0, 99);
    if (g < 60) return 0;
    if (g < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // each reading near the calibration point half of the time, else anywhere
  task automatic send_random(input int cnt, input logic gaps);
    logic [23:0] rp;
    logic [23:0] rt;
    for (int i = 0; i < cnt; i++) begin
      rp = 24'($urandom);
      rt = 24'($urandom);
      if ($urandom_range(0, 1) == 0) rp = 24'($urandom_range(5000000, 8000000));
      if ($urandom_range(0, 1) == 0) rt = 24'(cal_u16(0) * 256) + 24'($urandom_range(0, 1 << 19))
                                          - 24'(1 << 18);
      send_item(rp, rt, 1'b0, NOT_READY_RES, gaps ? rand_gap() : 0);
    end
  endtask

  dir_row_t dir_tab [12] = '{
    '{24'h000000, 24'h000000, 1'b0, 1'b1, NOT_READY_RES},
    '{24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1, NOT_READY_RES},
    '{24'h800000, 24'h7FFFFF, 1'b0, 1'b1, NOT_READY_RES},
    '{24'h555555, 24'hAAAAAA, 1'b0, 1'b1, NOT_READY_RES},
    '{24'h6A0000, 24'h6B8C00, 1'b1, 1'b0, NOT_READY_RES},
    '{24'h000000, 24'h000000, 1'b0, 1'b0, NOT_READY_RES},
    '{24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, NOT_READY_RES},
    '{24'h000000, 24'hFFFFFF, 1'b0, 1'b0, NOT_READY_RES},
    '{24'hFFFFFF, 24'h000000, 1'b0, 1'b0, NOT_READY_RES},
    '{24'h5F0000, 24'h7A0000, 1'b0, 1'b0, NOT_READY_RES},
    '{24'h740000, 24'h640000, 1'b0, 1'b0, NOT_READY_RES},
    '{24'h6B2C10, 24'h6B8BFF, 1'b0, 1'b0, NOT_READY_RES}
  };

  initial begin
    for (int i = 0; i < CalBytes; i++) cal_byte[i] = 8'd0;
    lim_min_pa = MIN_PA_RST;
    lim_max_pa = MAX_PA_RST;
    cal_loaded = 1'b0;
    err_cnt = 0;
    cycle_cnt = 0;
    hold_cycles = 0;
    rx_always_ready = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CAL_LO;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (30) @(negedge clk);

    // directed items
    foreach (dir_tab[i]) begin
      if (dir_tab[i].load_cal) begin
        wait_idle();
        write_reg(CFG_CAL_LO, TYP_CAL_LO);
        write_reg(CFG_CAL_MID, TYP_CAL_MID);
        write_reg(CFG_CAL_HI, {24'd0, TYP_CAL_HI});
        write_reg(CFG_LOADED, 64'd1);
      end
      send_item(dir_tab[i].raw_p, dir_tab[i].raw_t, dir_tab[i].typed, dir_tab[i].exp_res,
                rand_gap());
    end

    // phase: plausible calibration, widest limits, no idling on either side
    wait_idle();
    rx_always_ready = 1'b1;
    write_reg(CFG_MIN_PA, 64'd0);
    write_reg(CFG_MAX_PA, 64'd131071);
    send_random(PhaseItems, 1'b0);

    // phase: random calibration, random limits; long receiver hold while sending
    wait_idle();
    rx_always_ready = 1'b0;
    write_reg(CFG_CAL_LO, {$urandom, $urandom});
    write_reg(CFG_CAL_MID, {$urandom, $urandom});
    write_reg(CFG_CAL_HI, {$urandom, $urandom});
    write_reg(CFG_MIN_PA, {$urandom, $urandom});
    write_reg(CFG_MAX_PA, {$urandom, $urandom});
    hold_rx(300);
    send_random(PhaseItems, 1'b0);

    // phase: crossed limits; spare indexes must not disturb anything
    wait_idle();
    write_reg(CFG_CAL_LO, TYP_CAL_LO);
    write_reg(CFG_CAL_MID, TYP_CAL_MID);
    write_reg(CFG_CAL_HI, {24'd0, TYP_CAL_HI});
    write_reg(CFG_MIN_PA, 64'd131071);
    write_reg(CFG_MAX_PA, 64'd0);
    write_reg(CFG_SPARE_A, {$urandom, $urandom});
    write_reg(CFG_SPARE_B, {$urandom, $urandom});
    send_random(PhaseItems, 1'b1);

    // phase: calibration dropped again
    wait_idle();
    write_reg(CFG_LOADED, 64'hFFFF_FFFF_FFFF_FFFE);
    send_random(60, 1'b1);

    // phase: all-zero calibration, default limits
    wait_idle();
    write_reg(CFG_CAL_LO, 64'd0);
    write_reg(CFG_CAL_MID, 64'd0);
    write_reg(CFG_CAL_HI, 64'd0);
    write_reg(CFG_MIN_PA, {47'd0, MIN_PA_RST});
    write_reg(CFG_MAX_PA, {47'd0, MAX_PA_RST});
    write_reg(CFG_LOADED, 64'd1);
    send_random(60, 1'b1);

    // phases: random calibration and limits with random idling
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_reg(CFG_CAL_LO, {$urandom, $urandom});
      write_reg(CFG_CAL_MID, {$urandom, $urandom});
      write_reg(CFG_CAL_HI, {$urandom, $urandom});
      write_reg(CFG_MIN_PA, 64'($urandom_range(0, 60000)));
      write_reg(CFG_MAX_PA, 64'($urandom_range(60000, 131071)));
      if (ph == 2) hold_rx(200);
      send_random(PhaseItems, 1'b1);
    end

    // drain
    in_tvalid = 1'b0;
    while (pending_res_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/ptc_pkg.sv
src/ptc_calc.sv
src/pressure_temp_compensation.sv
tb/pressure_temp_compensation_tb.sv
